// File: rtl/core/obb_sat_pkg.sv
// obb_sat_pkg: beat types, corner sign table and saturation helper for the
// 2D OBB separating axis collider. No dependencies.
`default_nettype none

package obb_sat_pkg;

    typedef struct packed {
        logic signed [31:0] a_col0_x;
        logic signed [31:0] a_col0_y;
        logic signed [31:0] a_col1_x;
        logic signed [31:0] a_col1_y;
        logic signed [31:0] b_col0_x;
        logic signed [31:0] b_col0_y;
        logic signed [31:0] b_col1_x;
        logic signed [31:0] b_col1_y;
        logic signed [31:0] disp_x;
        logic signed [31:0] disp_y;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic [30:0]        depth;
    } rsp_t;

    // per-axis outcome: separated flag, signed overlap, its square, oriented normal
    typedef struct packed {
        logic               sepd;
        logic signed [31:0] sep;
        logic [63:0]        sq;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
    } axis_res_t;

    // corners {+,+} {-,+} {+,-} {-,-}: bit i set means that column is negated
    localparam logic [3:0] CRN_NEG0 = 4'b1010;
    localparam logic [3:0] CRN_NEG1 = 4'b1100;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/obb2d_sat_collide.sv
// obb2d_sat_collide: 2D OBB separating axis collider, top level.
// Depends on obb_sat_pkg, obb_sat_axis, obb_sat_proj.
// Fixed point with FRAC_BITS fraction bits (Q16.16 by default).
// Throughput: one beat per cycle; busy is never raised.
// Depth is set by the one-bit-per-stage square root and divider chains.
// Reset clears only the valid pipeline; results in flight are dropped.
`default_nettype none

module obb2d_sat_collide #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  obb_sat_pkg::req_t   req,
    output logic                done,
    output obb_sat_pkg::rsp_t   rsp
);
    import obb_sat_pkg::*;

    localparam int NW       = FRAC_BITS + 2;
    localparam int AXIS_LAT = FRAC_BITS + 37;
    localparam int PROJ_LAT = 6;
    localparam int TOT      = AXIS_LAT + PROJ_LAT + 3;
    localparam logic [63:0] EPS_SQ = (2 * FRAC_BITS >= 23)
        ? (64'd1 << ((2 * FRAC_BITS >= 23) ? (2 * FRAC_BITS - 23) : 0)) : 64'd0;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    logic [TOT:0] vld_reg;
    logic [TOT:0] vld_next;
    req_t         req_reg;
    req_t         dly_reg [0:AXIS_LAT-1];
    req_t         al;

    logic signed [NW-1:0] anx [4];
    logic signed [NW-1:0] any_ [4];
    logic [30:0]          aext [4];
    axis_res_t            ares [4];

    axis_res_t r01_reg, r23_reg, best_reg;
    axis_res_t r01_next, r23_next, best_next;
    rsp_t      rsp_reg;

    assign busy     = 1'b0;
    assign vld_next = {vld_reg[TOT-1:0], start && !busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req;
        dly_reg[0] <= req_reg;
        for (int j = 1; j < AXIS_LAT; j++)
            dly_reg[j] <= dly_reg[j-1];
    end

    assign al = dly_reg[AXIS_LAT-1];

    obb_sat_axis #(.FRAC_BITS(FRAC_BITS)) u_ax0 (
        .clk(clk), .col_x(req_reg.a_col0_x), .col_y(req_reg.a_col0_y),
        .nx(anx[0]), .ny(any_[0]), .ext(aext[0]));
    obb_sat_axis #(.FRAC_BITS(FRAC_BITS)) u_ax1 (
        .clk(clk), .col_x(req_reg.a_col1_x), .col_y(req_reg.a_col1_y),
        .nx(anx[1]), .ny(any_[1]), .ext(aext[1]));
    obb_sat_axis #(.FRAC_BITS(FRAC_BITS)) u_ax2 (
        .clk(clk), .col_x(req_reg.b_col0_x), .col_y(req_reg.b_col0_y),
        .nx(anx[2]), .ny(any_[2]), .ext(aext[2]));
    obb_sat_axis #(.FRAC_BITS(FRAC_BITS)) u_ax3 (
        .clk(clk), .col_x(req_reg.b_col1_x), .col_y(req_reg.b_col1_y),
        .nx(anx[3]), .ny(any_[3]), .ext(aext[3]));

    obb_sat_proj #(.FRAC_BITS(FRAC_BITS), .FROM_B(1'b0)) u_pr0 (
        .clk(clk), .nx(anx[0]), .ny(any_[0]), .ext(aext[0]),
        .opp_c0x(al.b_col0_x), .opp_c0y(al.b_col0_y),
        .opp_c1x(al.b_col1_x), .opp_c1y(al.b_col1_y),
        .dx(al.disp_x), .dy(al.disp_y), .res(ares[0]));
    obb_sat_proj #(.FRAC_BITS(FRAC_BITS), .FROM_B(1'b0)) u_pr1 (
        .clk(clk), .nx(anx[1]), .ny(any_[1]), .ext(aext[1]),
        .opp_c0x(al.b_col0_x), .opp_c0y(al.b_col0_y),
        .opp_c1x(al.b_col1_x), .opp_c1y(al.b_col1_y),
        .dx(al.disp_x), .dy(al.disp_y), .res(ares[1]));
    obb_sat_proj #(.FRAC_BITS(FRAC_BITS), .FROM_B(1'b1)) u_pr2 (
        .clk(clk), .nx(anx[2]), .ny(any_[2]), .ext(aext[2]),
        .opp_c0x(al.a_col0_x), .opp_c0y(al.a_col0_y),
        .opp_c1x(al.a_col1_x), .opp_c1y(al.a_col1_y),
        .dx(al.disp_x), .dy(al.disp_y), .res(ares[2]));
    obb_sat_proj #(.FRAC_BITS(FRAC_BITS), .FROM_B(1'b1)) u_pr3 (
        .clk(clk), .nx(anx[3]), .ny(any_[3]), .ext(aext[3]),
        .opp_c0x(al.a_col0_x), .opp_c0y(al.a_col0_y),
        .opp_c1x(al.a_col1_x), .opp_c1y(al.a_col1_y),
        .dx(al.disp_x), .dy(al.disp_y), .res(ares[3]));

    // strict less-than keeps the earlier axis on ties
    always_comb
    begin
        r01_next       = (ares[1].sq < ares[0].sq) ? ares[1] : ares[0];
        r01_next.sepd  = ares[0].sepd || ares[1].sepd;
        r23_next       = (ares[3].sq < ares[2].sq) ? ares[3] : ares[2];
        r23_next.sepd  = ares[2].sepd || ares[3].sepd;
        best_next      = (r23_reg.sq < r01_reg.sq) ? r23_reg : r01_reg;
        best_next.sepd = r01_reg.sepd || r23_reg.sepd;
    end

    always_ff @(posedge clk)
    begin
        r01_reg  <= r01_next;
        r23_reg  <= r23_next;
        best_reg <= best_next;
    end

    logic               neg;
    logic signed [33:0] mag;
    logic               hit;

    assign neg = best_reg.sep[31];
    assign mag = neg ? -34'(best_reg.sep) : 34'(best_reg.sep);
    assign hit = !best_reg.sepd && (best_reg.sq > EPS_SQ);

    always_ff @(posedge clk)
    begin
        rsp_reg.hit <= hit;
        if (hit)
        begin
            rsp_reg.normal_x <= neg ? -best_reg.nx : best_reg.nx;
            rsp_reg.normal_y <= neg ? -best_reg.ny : best_reg.ny;
            rsp_reg.depth    <= (mag > 34'sd2147483647) ? 31'h7fffffff : mag[30:0];
        end
        else
        begin
            rsp_reg.normal_x <= '0;
            rsp_reg.normal_y <= '0;
            rsp_reg.depth    <= '0;
        end
    end

    assign done = vld_reg[TOT];
    assign rsp  = rsp_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.hit) |-> (rsp.normal_x == 0 && rsp.normal_y == 0 && rsp.depth == 0))
        else $error("miss beat carries nonzero payload");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(TOT + 1) done)
        else $error("accepted beat did not complete on time");

    a_unit_x: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.hit) |-> (rsp.normal_x <= ONE && rsp.normal_x >= -ONE
                               && rsp.normal_y <= ONE && rsp.normal_y >= -ONE))
        else $error("normal component out of unit range");

endmodule

`default_nettype wire

// File: rtl/core/obb_sat_axis.sv
// obb_sat_axis: pipelined axis normalizer (square, bit-per-stage isqrt,
// restoring dividers). Standalone; used by obb2d_sat_collide.
`default_nettype none

module obb_sat_axis #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic signed [31:0]        col_x,
    input  logic signed [31:0]        col_y,
    output logic signed [FRAC_BITS+1:0] nx,
    output logic signed [FRAC_BITS+1:0] ny,
    output logic [30:0]               ext
);
    localparam int QW = FRAC_BITS + 1;
    localparam int DW = 32 + FRAC_BITS + 1;
    localparam int SQ_STEPS = 32;

    logic signed [63:0] xsq_next;
    logic signed [63:0] ysq_next;
    logic [63:0]        xsq_reg;
    logic [63:0]        ysq_reg;
    logic [65:0]        side_a_reg;

    logic [63:0] rem_s  [0:SQ_STEPS];
    logic [31:0] root_s [0:SQ_STEPS];
    logic [65:0] side_s [0:SQ_STEPS];

    logic [DW-1:0] drx_s [0:QW];
    logic [DW-1:0] dry_s [0:QW];
    logic [QW-1:0] qx_s  [0:QW];
    logic [QW-1:0] qy_s  [0:QW];
    logic [31:0]   len_s [0:QW];
    logic          sx_s  [0:QW];
    logic          sy_s  [0:QW];

    logic signed [FRAC_BITS+1:0] nx_reg;
    logic signed [FRAC_BITS+1:0] ny_reg;
    logic [30:0]                 ext_reg;

    assign xsq_next = 64'(col_x) * 64'(col_x);
    assign ysq_next = 64'(col_y) * 64'(col_y);

    always_ff @(posedge clk)
    begin
        xsq_reg    <= xsq_next;
        ysq_reg    <= ysq_next;
        side_a_reg <= {col_x[31], col_y[31],
                       col_x[31] ? 32'(-col_x) : 32'(col_x),
                       col_y[31] ? 32'(-col_y) : 32'(col_y)};
    end

    always_ff @(posedge clk)
    begin
        rem_s[0]  <= xsq_reg + ysq_reg;
        root_s[0] <= '0;
        side_s[0] <= side_a_reg;
    end

    for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sqrt
        localparam int K = SQ_STEPS - j;
        logic [63:0] trial;
        assign trial = ({32'd0, root_s[j-1]} << (K + 1)) + (64'd1 << (2 * K));
        always_ff @(posedge clk)
        begin
            if (rem_s[j-1] >= trial)
            begin
                rem_s[j]  <= rem_s[j-1] - trial;
                root_s[j] <= root_s[j-1] | (32'd1 << K);
            end
            else
            begin
                rem_s[j]  <= rem_s[j-1];
                root_s[j] <= root_s[j-1];
            end
            side_s[j] <= side_s[j-1];
        end
    end

    // dividend |c| * 2^F + len/2, rounded quotient
    always_ff @(posedge clk)
    begin
        drx_s[0] <= (DW'(side_s[SQ_STEPS][63:32]) << FRAC_BITS)
                    + DW'(root_s[SQ_STEPS] >> 1);
        dry_s[0] <= (DW'(side_s[SQ_STEPS][31:0]) << FRAC_BITS)
                    + DW'(root_s[SQ_STEPS] >> 1);
        qx_s[0]  <= '0;
        qy_s[0]  <= '0;
        len_s[0] <= root_s[SQ_STEPS];
        sx_s[0]  <= side_s[SQ_STEPS][65];
        sy_s[0]  <= side_s[SQ_STEPS][64];
    end

    for (genvar j = 1; j <= QW; j++) begin : g_div
        localparam int K = QW - j;
        logic [DW-1:0] dv;
        assign dv = DW'(len_s[j-1]) << K;
        always_ff @(posedge clk)
        begin
            if (drx_s[j-1] >= dv)
            begin
                drx_s[j] <= drx_s[j-1] - dv;
                qx_s[j]  <= qx_s[j-1] | (QW'(1) << K);
            end
            else
            begin
                drx_s[j] <= drx_s[j-1];
                qx_s[j]  <= qx_s[j-1];
            end
            if (dry_s[j-1] >= dv)
            begin
                dry_s[j] <= dry_s[j-1] - dv;
                qy_s[j]  <= qy_s[j-1] | (QW'(1) << K);
            end
            else
            begin
                dry_s[j] <= dry_s[j-1];
                qy_s[j]  <= qy_s[j-1];
            end
            len_s[j] <= len_s[j-1];
            sx_s[j]  <= sx_s[j-1];
            sy_s[j]  <= sy_s[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_s[QW] == 32'd0)
        begin
            nx_reg <= '0;
            ny_reg <= '0;
        end
        else
        begin
            nx_reg <= sx_s[QW] ? -$signed({1'b0, qx_s[QW]}) : $signed({1'b0, qx_s[QW]});
            ny_reg <= sy_s[QW] ? -$signed({1'b0, qy_s[QW]}) : $signed({1'b0, qy_s[QW]});
        end
        ext_reg <= len_s[QW][31] ? 31'h7fffffff : len_s[QW][30:0];
    end

    assign nx  = nx_reg;
    assign ny  = ny_reg;
    assign ext = ext_reg;

endmodule

`default_nettype wire

// File: rtl/core/obb_sat_proj.sv
// obb_sat_proj: six-stage corner projection and overlap for one axis.
// Depends on obb_sat_pkg.
`default_nettype none

module obb_sat_proj #(
    parameter int FRAC_BITS = 16,
    parameter bit FROM_B    = 1'b0
) (
    input  logic                        clk,
    input  logic signed [FRAC_BITS+1:0] nx,
    input  logic signed [FRAC_BITS+1:0] ny,
    input  logic [30:0]                 ext,
    input  logic signed [31:0]          opp_c0x,
    input  logic signed [31:0]          opp_c0y,
    input  logic signed [31:0]          opp_c1x,
    input  logic signed [31:0]          opp_c1y,
    input  logic signed [31:0]          dx,
    input  logic signed [31:0]          dy,
    output obb_sat_pkg::axis_res_t      res
);
    import obb_sat_pkg::*;

    localparam int NW = FRAC_BITS + 2;

    logic signed [31:0]   px_reg [4];
    logic signed [31:0]   py_reg [4];
    logic signed [NW+31:0] prx_reg [4];
    logic signed [NW+31:0] pry_reg [4];
    logic signed [31:0]   p_reg  [4];
    logic signed [31:0]   mn_reg;
    logic signed [31:0]   mx_reg;
    logic signed [31:0]   sep_reg;
    logic                 sepd_reg;
    logic signed [31:0]   sep6_reg;
    logic                 sepd6_reg;
    logic [63:0]          sq_reg;
    logic signed [31:0]   nxo_reg;
    logic signed [31:0]   nyo_reg;

    logic signed [NW-1:0] nx_d [1:5];
    logic signed [NW-1:0] ny_d [1:5];
    logic [30:0]          ext_d [1:4];

    logic signed [33:0] ddx;
    logic signed [33:0] ddy;

    assign ddx = FROM_B ? -34'(dx) : 34'(dx);
    assign ddy = FROM_B ? -34'(dy) : 34'(dy);

    for (genvar i = 0; i < 4; i++) begin : g_crn
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [63:0] v;
        assign cx = (CRN_NEG0[i] ? -34'(opp_c0x) : 34'(opp_c0x))
                  + (CRN_NEG1[i] ? -34'(opp_c1x) : 34'(opp_c1x)) + ddx;
        assign cy = (CRN_NEG0[i] ? -34'(opp_c0y) : 34'(opp_c0y))
                  + (CRN_NEG1[i] ? -34'(opp_c1y) : 34'(opp_c1y)) + ddy;
        assign v  = 64'(prx_reg[i]) + 64'(pry_reg[i]) + (64'sd1 <<< (FRAC_BITS - 1));
        always_ff @(posedge clk)
        begin
            px_reg[i]  <= sat32(64'(cx));
            py_reg[i]  <= sat32(64'(cy));
            prx_reg[i] <= (NW+32)'(nx_d[1]) * (NW+32)'(px_reg[i]);
            pry_reg[i] <= (NW+32)'(ny_d[1]) * (NW+32)'(py_reg[i]);
            p_reg[i]   <= sat32(v >>> FRAC_BITS);
        end
    end

    logic signed [31:0] mn01, mn23, mx01, mx23;
    logic signed [33:0] e34;
    logic signed [31:0] dmin, dmax;

    assign mn01 = (p_reg[1] < p_reg[0]) ? p_reg[1] : p_reg[0];
    assign mn23 = (p_reg[3] < p_reg[2]) ? p_reg[3] : p_reg[2];
    assign mx01 = (p_reg[1] > p_reg[0]) ? p_reg[1] : p_reg[0];
    assign mx23 = (p_reg[3] > p_reg[2]) ? p_reg[3] : p_reg[2];

    assign e34  = $signed({3'b000, ext_d[4]});
    assign dmin = sat32(64'(e34 - 34'(mn_reg)));
    assign dmax = sat32(64'(-e34 - 34'(mx_reg)));

    always_ff @(posedge clk)
    begin
        nx_d[1]  <= nx;
        ny_d[1]  <= ny;
        ext_d[1] <= ext;
        for (int j = 2; j <= 5; j++)
        begin
            nx_d[j] <= nx_d[j-1];
            ny_d[j] <= ny_d[j-1];
        end
        for (int j = 2; j <= 4; j++)
            ext_d[j] <= ext_d[j-1];

        mn_reg   <= (mn23 < mn01) ? mn23 : mn01;
        mx_reg   <= (mx23 > mx01) ? mx23 : mx01;

        sepd_reg <= (34'(mn_reg) >= e34) || (34'(mx_reg) <= -e34);
        sep_reg  <= (34'(dmin) <= -34'(dmax)) ? dmin : dmax;

        sepd6_reg <= sepd_reg;
        sep6_reg  <= sep_reg;
        sq_reg    <= 64'(64'(sep_reg) * 64'(sep_reg));
        nxo_reg   <= FROM_B ? -32'(nx_d[5]) : 32'(nx_d[5]);
        nyo_reg   <= FROM_B ? -32'(ny_d[5]) : 32'(ny_d[5]);
    end

    assign res.sepd = sepd6_reg;
    assign res.sep  = sep6_reg;
    assign res.sq   = sq_reg;
    assign res.nx   = nxo_reg;
    assign res.ny   = nyo_reg;

endmodule

`default_nettype wire

// File: tb/tb.sv
// tb: self-checking testbench for obb2d_sat_collide, the 2D OBB separating axis collider.
// Depends on obb_sat_pkg. It runs a directed table, then random box pairs, and checks
// each result against an in-bench contact predictor or, for typed rows, the table's expected value.
`timescale 1ns / 100ps

module tb;
    import obb_sat_pkg::*;

    localparam int  FRAC      = 16;
    localparam longint S32MAX = 64'sd2147483647;
    localparam longint S32MIN = -64'sd2147483648;
    localparam longint unsigned EPS_SQ = (2 * FRAC >= 23) ? (64'd1 << (2 * FRAC - 23)) : 64'd0;
    localparam int  N_RAND    = 1280;
    localparam int  LAT       = FRAC + 47;
    localparam int  LIMIT     = 400000;
    localparam longint ONE    = 64'sd1 << FRAC;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    req_t req;
    rsp_t rsp;

    rsp_t contacts_due[$];
    int   mismatches;
    int   cycles;

    typedef struct {
        req_t r;
        bit   typed;
        rsp_t want;
    } row_t;

    obb2d_sat_collide #(.FRAC_BITS(FRAC)) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .req  (req),
        .done (done),
        .rsp  (rsp)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint clamp32(longint v);
        if (v > S32MAX)
            return S32MAX;
        if (v < S32MIN)
            return S32MIN;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unit_comp(longint c, longint unsigned len);
        longint unsigned m;
        longint unsigned q;
        m = (c < 0) ? longint'(-c) : longint'(c);
        q = ((m << FRAC) + len / 2) / len;
        return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    // returns 1 when the axis separates the boxes
    function automatic bit axis_separates(longint nx, longint ny, longint ext,
                                          longint dx, longint dy, longint m[4],
                                          output longint sep);
        longint s0[4];
        longint s1[4];
        longint px;
        longint py;
        longint p;
        longint mn;
        longint mx;
        longint dmin;
        longint dmax;
        s0 = '{1, -1, 1, -1};
        s1 = '{1, 1, -1, -1};
        mn = 0;
        mx = 0;
        sep = 0;
        for (int i = 0; i < 4; i++)
        begin
            px = clamp32(s0[i] * m[0] + s1[i] * m[2] + dx);
            py = clamp32(s0[i] * m[1] + s1[i] * m[3] + dy);
            p = clamp32((nx * px + ny * py + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
            if (i == 0 || p < mn)
                mn = p;
            if (i == 0 || p > mx)
                mx = p;
        end
        if (mn >= ext || mx <= -ext)
            return 1'b1;
        dmin = clamp32(ext - mn);
        dmax = clamp32(-ext - mx);
        sep = (dmin <= -dmax) ? dmin : dmax;
        return 1'b0;
    endfunction

    function automatic rsp_t predict_contact(req_t r);
        longint ma[4];
        longint mb[4];
        longint own[4];
        longint opp[4];
        longint x;
        longint y;
        longint nx;
        longint ny;
        longint ext;
        longint dx;
        longint dy;
        longint sep;
        longint best_sep;
        longint best_nx;
        longint best_ny;
        longint unsigned len;
        longint unsigned sq;
        longint unsigned best_sq;
        bit from_b;
        rsp_t o;
        ma = '{r.a_col0_x, r.a_col0_y, r.a_col1_x, r.a_col1_y};
        mb = '{r.b_col0_x, r.b_col0_y, r.b_col1_x, r.b_col1_y};
        best_sep = 0;
        best_nx = 0;
        best_ny = 0;
        best_sq = '1;
        o = '0;
        for (int i = 0; i < 4; i++)
        begin
            from_b = (i >= 2);
            if (from_b)
            begin
                own = mb;
                opp = ma;
            end
            else
            begin
                own = ma;
                opp = mb;
            end
            x = own[2 * (i & 1)];
            y = own[2 * (i & 1) + 1];
            len = int_sqrt(longint'(x * x) + longint'(y * y));
            if (len == 0)
            begin
                nx = 0;
                ny = 0;
                ext = 0;
            end
            else
            begin
                nx = unit_comp(x, len);
                ny = unit_comp(y, len);
                ext = (len > S32MAX) ? S32MAX : longint'(len);
            end
            dx = from_b ? -longint'(r.disp_x) : longint'(r.disp_x);
            dy = from_b ? -longint'(r.disp_y) : longint'(r.disp_y);
            if (axis_separates(nx, ny, ext, dx, dy, opp, sep))
                return o;
            sq = sep * sep;
            if (sq < best_sq)
            begin
                best_sq = sq;
                best_sep = sep;
                best_nx = from_b ? -nx : nx;
                best_ny = from_b ? -ny : ny;
            end
        end
        if (best_sep < 0)
        begin
            best_sep = -best_sep;
            best_nx = -best_nx;
            best_ny = -best_ny;
        end
        if (best_sq <= EPS_SQ)
            return o;
        if (best_sep > S32MAX)
            best_sep = S32MAX;
        o.hit = 1'b1;
        o.normal_x = best_nx[31:0];
        o.normal_y = best_ny[31:0];
        o.depth = best_sep[30:0];
        return o;
    endfunction

    function automatic logic [31:0] near_val(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic req_t random_pair();
        req_t r;
        int   span;
        int   kind;
        kind = $urandom_range(0, 99);
        if (kind < 15)
            r = {$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom};
        else
        begin
            span = (kind < 85) ? (1 << 18) : (1 << 29);
            r.a_col0_x = near_val(span);
            r.a_col0_y = near_val(span);
            r.a_col1_x = near_val(span);
            r.a_col1_y = near_val(span);
            r.b_col0_x = near_val(span);
            r.b_col0_y = near_val(span);
            r.b_col1_x = near_val(span);
            r.b_col1_y = near_val(span);
            r.disp_x = near_val(span);
            r.disp_y = near_val(span);
            if ($urandom_range(0, 19) == 0)
                r.b_col1_x = 0;
            if ($urandom_range(0, 19) == 0)
                r.b_col1_y = 0;
        end
        return r;
    endfunction

    task automatic send_beat(req_t r, bit gaps);
        while (gaps && $urandom_range(0, 99) < 6)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        contacts_due.push_back(predict_contact(r));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (contacts_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", rsp);
            end
            else
            begin
                if (rsp !== contacts_due[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", contacts_due[0], rsp);
                end
                void'(contacts_due.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        row_t rows[$];
        row_t w;
        rsp_t hit_x;
        mismatches = 0;
        cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        hit_x = '0;
        hit_x.hit = 1'b1;
        hit_x.normal_x = 32'(ONE);
        hit_x.depth = 31'(ONE + ONE / 2);

        // all zero: zero-length axes, no hit
        w.r = '0; w.typed = 1; w.want = '0; rows.push_back(w);
        // unit boxes offset by half a unit along x
        w.r = '{32'(ONE), 0, 0, 32'(ONE), 32'(ONE), 0, 0, 32'(ONE), 32'(ONE / 2), 0};
        w.typed = 1; w.want = hit_x; rows.push_back(w);
        // same boxes, far apart: separated
        w.r.disp_x = 32'(3 * ONE); w.want = '0; rows.push_back(w);
        // touching exactly: separated
        w.r.disp_x = 32'(2 * ONE); rows.push_back(w);
        // tiny overlap below epsilon
        w.r.disp_x = 32'(2 * ONE - 1); w.typed = 0; rows.push_back(w);
        // zero column on B only
        w.r = '{32'(ONE), 0, 0, 32'(ONE), 0, 0, 0, 32'(ONE), 0, 0};
        w.typed = 1; w.want = '0; rows.push_back(w);
        w.typed = 0;
        w.r = {10{32'h7fffffff}}; rows.push_back(w);
        w.r = {10{32'h80000000}}; rows.push_back(w);
        w.r = {32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
               32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h0, 32'h0};
        rows.push_back(w);
        w.r = {{8{32'hffffffff}}, 32'h0, 32'h0}; rows.push_back(w);
        w.r = {{8{32'h00000001}}, 32'h0, 32'h0}; rows.push_back(w);
        // rotated boxes, deep overlap, negative and mixed disp
        w.r = '{32'(ONE), 32'(ONE), -32'(ONE), 32'(ONE), 32'(2 * ONE), 0, 0, 32'(ONE),
                -32'(ONE / 4), 32'(ONE / 3)};
        rows.push_back(w);
        w.r = '{32'(3 * ONE), 32'(ONE), -32'(ONE), 32'(3 * ONE), 32'(ONE), -32'(2 * ONE),
                32'(2 * ONE), 32'(ONE), 32'(ONE), -32'(2 * ONE)};
        rows.push_back(w);
        // identical centered boxes: tie between axes
        w.r = '{32'(ONE), 0, 0, 32'(ONE), 32'(ONE), 0, 0, 32'(ONE), 0, 0};
        rows.push_back(w);
        w.r = '{32'(ONE), 0, 0, 32'(ONE), 32'(ONE), 0, 0, 32'(ONE), 0, -32'(ONE / 2)};
        rows.push_back(w);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_beat(rows[i].r, 1'b1);
            if (rows[i].typed && contacts_due[$] !== rows[i].want)
            begin
                contacts_due[$] = rows[i].want;
            end
        end
        for (int n = 0; n < N_RAND; n++)
        begin
            if (n == 600)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (contacts_due.size() != 0)
                    @(posedge clk);
            end
            send_beat(random_pair(), !(n >= 300 && n < 600));
        end
        start <= 1'b0;
        while (contacts_due.size() != 0)
            @(posedge clk);
        repeat (LAT + 20) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
